/* src/keyed_slot_find_or_insert_assert.svh */
// assertion macros for the keyed slot table
// every check is sampled on the rising edge of clk_i
`ifndef KEYED_SLOT_FIND_OR_INSERT_ASSERT_SVH
`define KEYED_SLOT_FIND_OR_INSERT_ASSERT_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is held
`define KSFI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also runs while reset is held
`define KSFI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define KSFI_ASSERT(lbl, prop, msg)
`define KSFI_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* src/ksfi_pkg.sv */
package ksfi_pkg;

  localparam int SlotCount = 16;
  localparam int SlotIdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int DataW     = 32;
  localparam int IdxOutW   = 4;

  localparam logic [SlotIdxW-1:0] LastSlot = SlotIdxW'(SlotCount - 1);

  typedef enum logic [1:0] {
    OUT_FOUND   = 2'd0,
    OUT_CREATED = 2'd1,
    OUT_FULL    = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic [DataW-1:0] lookup_key;
    logic [DataW-1:0] data_first;
    logic [DataW-1:0] data_second;
  } ksfi_req_t;

  typedef struct packed {
    outcome_e           outcome;
    logic [IdxOutW-1:0] slot_index;
    logic [DataW-1:0]   entry_sequence;
    logic [DataW-1:0]   entry_key;
    logic [DataW-1:0]   entry_first;
    logic [DataW-1:0]   entry_second;
  } ksfi_rsp_t;

  typedef struct packed {
    logic [DataW-1:0] key;
    logic [DataW-1:0] first;
    logic [DataW-1:0] second;
    logic [DataW-1:0] seq_num;
  } ksfi_entry_t;

  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic cap_found;
    logic cap_full;
    logic fill;
    logic push;
  } ksfi_cmd_t;

  typedef struct packed {
    logic hit;
    logic cmp_last;
    logic have_empty;
  } ksfi_sts_t;

endpackage

/* src/keyed_slot_find_or_insert.sv */
// keyed slot table with find-or-insert, one request in the sequencer at a time
// the scan compares one slot per cycle from slot 0 up and ends at the first hit;
// a miss scans every slot, then fills an empty slot or answers table full; the
// result waits while the last result is still held, and a new request is taken
// only once that result has moved to the output register
// reset (async, active low): every slot empty, sequence counter zero, no result
module keyed_slot_find_or_insert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ksfi_pkg::ksfi_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ksfi_pkg::ksfi_rsp_t out_rsp_o
);
  import ksfi_pkg::*;

`include "keyed_slot_find_or_insert_assert.svh"

  // command and status between sequencer and datapath
  ksfi_cmd_t cmd;
  ksfi_sts_t sts;

  // sequencer: idle -> scan until a hit or the last slot -> optional fill -> hand result to output
  // the output register frees the sequencer to take the next request while a
  // finished result still waits for the consumer
  ksfi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: slot memory, occupied bits, scan counter with a registered
  // compare stage, highest empty slot tracker, sequence counter and the
  // pending and output result registers
  ksfi_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

  // an accepted request always makes the block busy for the next cycle
  `KSFI_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")

  // a fill only follows a scan that saw an empty slot
  `KSFI_ASSERT(a_fill_needs_empty, cmd.fill |-> $past(sts.have_empty), "fill without empty slot")

  // a full result carries a zero slot index, key and sequence
  `KSFI_ASSERT(a_full_zero, (out_valid_o && out_rsp_o.outcome == OUT_FULL) |-> (out_rsp_o.slot_index == '0 && out_rsp_o.entry_key == '0 && out_rsp_o.entry_sequence == '0), "full result not zero")

  // the datapath never sees two commands that load the pending result at once
  `KSFI_ASSERT_ALWAYS(a_one_capture, $onehot0({cmd.cap_found, cmd.cap_full, cmd.fill}), "capture clash")

endmodule

/* src/ksfi_ctrl.sv */
module ksfi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ksfi_pkg::ksfi_sts_t sts_i,
  output ksfi_pkg::ksfi_cmd_t cmd_o
);
  import ksfi_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_RESP;
        end else if (sts_i.cmp_last) begin
          state_d = sts_i.have_empty ? ST_FILL : ST_RESP;
        end
      end
      ST_FILL: state_d = ST_RESP;
      ST_RESP: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.cap_found = sts_i.hit;
        cmd_o.cap_full  = !sts_i.hit && sts_i.cmp_last && !sts_i.have_empty;
      end
      ST_FILL: cmd_o.fill = 1'b1;
      ST_RESP: cmd_o.push = slot_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/ksfi_dp.sv */
module ksfi_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ksfi_pkg::ksfi_cmd_t cmd_i,
  input  ksfi_pkg::ksfi_req_t req_i,
  output ksfi_pkg::ksfi_sts_t sts_o,
  output ksfi_pkg::ksfi_rsp_t rsp_o
);
  import ksfi_pkg::*;

  ksfi_entry_t          mem_q [SlotCount];
  ksfi_entry_t          rd_q;
  logic [SlotCount-1:0] occ_q;
  logic                 rd_occ_q;
  logic [SlotIdxW-1:0]  scan_cnt_q, rd_idx_q, empty_idx_q;
  logic                 cmp_vld_q, have_empty_q;
  ksfi_req_t            req_q;
  logic [DataW-1:0]     seq_q, seq_inc;
  ksfi_rsp_t            res_q, out_q;
  logic                 cmp_en, cur_empty;

  assign seq_inc   = seq_q + DataW'(1);
  assign cmp_en    = cmp_vld_q && cmd_i.rd_en;
  assign cur_empty = cmp_en && !rd_occ_q;

  assign sts_o.hit        = cmp_en && rd_occ_q && (rd_q.key == req_q.lookup_key);
  assign sts_o.cmp_last   = cmp_en && (rd_idx_q == LastSlot);
  assign sts_o.have_empty = have_empty_q || cur_empty;

  // slot storage, no reset: only occupied slots are ever compared
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      mem_q[empty_idx_q] <= '{key:     req_q.lookup_key,
                              first:   req_q.data_first,
                              second:  req_q.data_second,
                              seq_num: seq_inc};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[scan_cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q        <= '0;
      rd_occ_q     <= 1'b0;
      scan_cnt_q   <= '0;
      rd_idx_q     <= '0;
      empty_idx_q  <= '0;
      cmp_vld_q    <= 1'b0;
      have_empty_q <= 1'b0;
      seq_q        <= '0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      if (cmd_i.load_req) begin
        scan_cnt_q   <= '0;
        have_empty_q <= 1'b0;
      end else begin
        if (cmd_i.rd_en) begin
          rd_occ_q <= occ_q[scan_cnt_q];
          rd_idx_q <= scan_cnt_q;
          if (scan_cnt_q != LastSlot) scan_cnt_q <= scan_cnt_q + SlotIdxW'(1);
        end
        if (cur_empty) begin
          have_empty_q <= 1'b1;
          empty_idx_q  <= rd_idx_q;
        end
      end
      if (cmd_i.fill) begin
        occ_q[empty_idx_q] <= 1'b1;
        seq_q              <= seq_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.cap_found) begin
      res_q <= '{outcome:        OUT_FOUND,
                 slot_index:     IdxOutW'(rd_idx_q),
                 entry_sequence: rd_q.seq_num,
                 entry_key:      rd_q.key,
                 entry_first:    rd_q.first,
                 entry_second:   rd_q.second};
    end else if (cmd_i.cap_full) begin
      res_q <= '{outcome: OUT_FULL, slot_index: '0, entry_sequence: '0,
                 entry_key: '0, entry_first: '0, entry_second: '0};
    end else if (cmd_i.fill) begin
      res_q <= '{outcome:        OUT_CREATED,
                 slot_index:     IdxOutW'(empty_idx_q),
                 entry_sequence: seq_inc,
                 entry_key:      req_q.lookup_key,
                 entry_first:    req_q.data_first,
                 entry_second:   req_q.data_second};
    end
    if (cmd_i.push) out_q <= res_q;
  end

  assign rsp_o = out_q;

endmodule

/* dv/keyed_slot_find_or_insert_tb.sv */
module keyed_slot_find_or_insert_tb;
  import ksfi_pkg::*;

  // clock, reset and the two request / result channels
  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  ksfi_req_t in_req_i;
  logic      out_valid_o;
  logic      out_ready_i;
  ksfi_rsp_t out_rsp_o;

  keyed_slot_find_or_insert dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // one row of the directed part; typed rows carry a hand-written result,
  // the others take whatever the shadow table predicts
  typedef struct {
    ksfi_req_t req;
    bit        typed;
    ksfi_rsp_t rsp;
  } stim_row_t;

  localparam int RandomRequests = 1500;

  // shadow copy of the slot table and the sequence counter
  bit          shadow_used [SlotCount];
  ksfi_entry_t shadow_entry [SlotCount];
  logic [31:0] shadow_seq;

  ksfi_rsp_t   pending_results[$];
  stim_row_t   stim_rows[$];
  int          error_count;
  int          found_seen;
  int          created_seen;
  int          full_seen;
  bit          sender_calm;
  bit          sink_calm;

  // free-running clock, period of two time units
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #1_200_000;
    $display("keyed_slot_find_or_insert_tb: FAIL");
    $finish;
  end

  // one line per mismatch, counted for the final verdict
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // lowest occupied slot holding the key wins; otherwise the highest empty
  // slot is filled with the pre-incremented counter; otherwise table full
  function automatic ksfi_rsp_t predict_find_or_insert(input ksfi_req_t req);
    ksfi_rsp_t rsp;
    int        hit_slot;
    int        free_slot;
    int        pick;
    rsp       = '0;
    hit_slot  = -1;
    free_slot = -1;
    for (int s = 0; s < SlotCount; s++) begin
      if (!shadow_used[s]) begin
        free_slot = s;
      end else if (hit_slot < 0 && shadow_entry[s].key == req.lookup_key) begin
        hit_slot = s;
      end
    end
    if (hit_slot >= 0) begin
      // stored entry comes back untouched, request words are dropped
      pick        = hit_slot;
      rsp.outcome = OUT_FOUND;
    end else if (free_slot >= 0) begin
      shadow_seq              = shadow_seq + 32'd1;
      shadow_used[free_slot]  = 1'b1;
      shadow_entry[free_slot] = '{key: req.lookup_key, first: req.data_first,
                                  second: req.data_second, seq_num: shadow_seq};
      pick        = free_slot;
      rsp.outcome = OUT_CREATED;
    end else begin
      // full: every other field reads zero and the counter holds
      rsp.outcome = OUT_FULL;
      return rsp;
    end
    rsp.slot_index     = IdxOutW'(pick);
    rsp.entry_sequence = shadow_entry[pick].seq_num;
    rsp.entry_key      = shadow_entry[pick].key;
    rsp.entry_first    = shadow_entry[pick].first;
    rsp.entry_second   = shadow_entry[pick].second;
    return rsp;
  endfunction

  task automatic add_row(input logic [31:0] key, input logic [31:0] first,
                         input logic [31:0] second, input bit typed,
                         input ksfi_rsp_t rsp);
    stim_row_t row;
    row.req   = '{lookup_key: key, data_first: first, data_second: second};
    row.typed = typed;
    row.rsp   = rsp;
    stim_rows.push_back(row);
  endtask

  // present one request and hold it until accepted; valid is only lowered
  // when a gap actually follows, so it never drops and rises in one step
  task automatic send_request(input ksfi_req_t req, input bit typed,
                              input ksfi_rsp_t typed_rsp);
    int        gap;
    ksfi_rsp_t predicted;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: advance the shadow table in request order
    predicted = predict_find_or_insert(req);
    pending_results.push_back(typed ? typed_rsp : predicted);
  endtask

  // result side: random stalls on ready, each accepted result checked
  // field by field against the oldest pending expectation
  initial begin
    int        gap;
    ksfi_rsp_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      case (out_rsp_o.outcome)
        OUT_FOUND:   found_seen++;
        OUT_CREATED: created_seen++;
        default:     full_seen++;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, outcome",
                        32'(out_rsp_o.outcome), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp_o.outcome !== want.outcome)
          report_mismatch("outcome", 32'(out_rsp_o.outcome), 32'(want.outcome));
        if (out_rsp_o.slot_index !== want.slot_index)
          report_mismatch("slot_index", 32'(out_rsp_o.slot_index), 32'(want.slot_index));
        if (out_rsp_o.entry_sequence !== want.entry_sequence)
          report_mismatch("entry_sequence", out_rsp_o.entry_sequence, want.entry_sequence);
        if (out_rsp_o.entry_key !== want.entry_key)
          report_mismatch("entry_key", out_rsp_o.entry_key, want.entry_key);
        if (out_rsp_o.entry_first !== want.entry_first)
          report_mismatch("entry_first", out_rsp_o.entry_first, want.entry_first);
        if (out_rsp_o.entry_second !== want.entry_second)
          report_mismatch("entry_second", out_rsp_o.entry_second, want.entry_second);
      end
    end
  end

  // request side: reset, directed rows, random traffic, drain, verdict
  initial begin
    ksfi_req_t   req;
    ksfi_rsp_t   full_rsp;
    logic [31:0] stored;
    int          kind;
    int          drain;

    // every input known from time zero while reset is held
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_ready_i  = 1'b0;
    error_count  = 0;
    found_seen   = 0;
    created_seen = 0;
    full_seen    = 0;
    sender_calm  = 1'b0;
    sink_calm    = 1'b0;
    shadow_seq   = '0;
    foreach (shadow_used[s]) begin
      shadow_used[s]  = 1'b0;
      shadow_entry[s] = '0;
    end
    full_rsp         = '0;
    full_rsp.outcome = OUT_FULL;

    // empty table fills from the top slot down, counter starts at one
    add_row(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
            '{OUT_CREATED, 4'd15, 32'd1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
    add_row(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
            '{OUT_CREATED, 4'd14, 32'd2, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    // repeat keys: stored words come back, the new words are dropped
    add_row(32'h0000_0000, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1,
            '{OUT_FOUND, 4'd15, 32'd1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
    add_row(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1,
            '{OUT_FOUND, 4'd14, 32'd2, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    // walking-one keys take the remaining slots, thirteen down to zero
    for (int b = 0; b < SlotCount - 2; b++)
      add_row(32'h1 << b, $urandom, $urandom, 1'b0, '0);
    // no empty slot left: full, all fields zero
    add_row(32'h8000_0000, $urandom, $urandom, 1'b1, full_rsp);
    // hit in the lowest slot, then a one-bit near miss of a stored key
    add_row(32'h1 << (SlotCount - 3), $urandom, $urandom, 1'b0, '0);
    add_row(32'hFFFF_FFFE, $urandom, $urandom, 1'b1, full_rsp);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[r])
      send_request(stim_rows[r].req, stim_rows[r].typed, stim_rows[r].rsp);

    // random part: with no removal the table stays full, so the mix is
    // mostly hits on stored keys plus near misses and fresh keys
    for (int n = 0; n < RandomRequests; n++) begin
      // calm stretches with no idling on one side or the other
      if (n % 64 == 0) begin
        sender_calm = ($urandom_range(0, 3) == 0);
        sink_calm   = ($urandom_range(0, 3) == 0);
      end
      // let the block drain completely once, then resume
      if (n == RandomRequests / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      stored = shadow_entry[$urandom_range(0, SlotCount - 1)].key;
      kind   = $urandom_range(0, 99);
      if (kind < 55)
        req.lookup_key = stored;
      else if (kind < 75)
        req.lookup_key = stored ^ (32'h1 << $urandom_range(0, 31));
      else
        req.lookup_key = $urandom;
      case ($urandom_range(0, 7))
        0:       begin req.data_first = '0;            req.data_second = '1;      end
        1:       begin req.data_first = '1;            req.data_second = '0;      end
        default: begin req.data_first = $urandom;      req.data_second = $urandom; end
      endcase
      send_request(req, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // wait out every pending result, then a little longer for strays
    while (pending_results.size() != 0) @(posedge clk_i);
    drain = 40;
    repeat (drain) @(posedge clk_i);

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 32'd0);

    $display("checked %0d results: %0d found, %0d created, %0d table full",
             found_seen + created_seen + full_seen, found_seen, created_seen, full_seen);
    $display("table filled top down, hits on every slot, near misses and full answers");
    if (error_count == 0) begin
      $display("keyed_slot_find_or_insert_tb: PASS");
    end else begin
      $display("keyed_slot_find_or_insert_tb: FAIL");
    end
    $finish;
  end

endmodule
